### sv/shift_log_button_debouncer_core_macros.svh
// Assertion macros shared by the button debouncer RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef SHIFT_LOG_BUTTON_DEBOUNCER_CORE_MACROS_SVH
`define SHIFT_LOG_BUTTON_DEBOUNCER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/sld_pkg.sv
// Package for the shift-register button debouncer.
// Holds sizes, request and register codes, and the structs passed between modules.
`timescale 1ns / 1ps

package sld_pkg;

    localparam int BUTTON_COUNT  = 16;
    localparam int HIST_LEN      = 8;
    localparam int CLICK_REPEATS = 4;
    localparam int BTN_IDX_W     = $clog2(BUTTON_COUNT);
    localparam int CLICK_W       = 3;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int IN_DATA_W     = 16;
    localparam int OUT_DATA_W    = 24;

    // Kind of request carried on the input stream.
    typedef enum logic [0:0] {
        REQ_SAMPLE = 1'b0,
        REQ_QUERY  = 1'b1
    } req_type_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QC_MASK  = 2'd0,
        CFG_SHOP_IDX = 2'd1,
        CFG_QC_IDX   = 2'd2
    } cfg_index_t;

    // State-update strobes for the request leaving the input register.
    typedef struct packed {
        logic sample;
        logic query;
    } step_t;

    // Debounce events for the current sample, and the debounced state after it.
    typedef struct packed {
        logic [BUTTON_COUNT-1:0] press_evt;
        logic [BUTTON_COUNT-1:0] rel_evt;
        logic [BUTTON_COUNT-1:0] pressed_now;
        logic [BUTTON_COUNT-1:0] pressed_after;
    } btn_evt_t;

    // Quickcast outputs for the current request.
    typedef struct packed {
        logic               pulse;
        logic               mode_now;
        logic               mode_after;
        logic [CLICK_W-1:0] click_now;
    } qc_result_t;

endpackage

### sv/sld_history.sv
// Per-button sample history shift registers and debounced pressed flags.
// Depends on sld_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "shift_log_button_debouncer_core_macros.svh"

module sld_history (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sld_pkg::step_t                   step,
    input  logic [sld_pkg::BUTTON_COUNT-1:0] pins,
    output sld_pkg::btn_evt_t                evt
);
    import sld_pkg::*;

    logic [HIST_LEN-1:0]     hist_reg  [BUTTON_COUNT];
    logic [HIST_LEN-1:0]     hist_next [BUTTON_COUNT];
    logic [BUTTON_COUNT-1:0] pressed_reg;
    logic [BUTTON_COUNT-1:0] pressed_next;
    logic [BUTTON_COUNT-1:0] press_evt;
    logic [BUTTON_COUNT-1:0] rel_evt;

    // Shift each raw level in and detect a settled low or settled high history.
    always_comb
    begin
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            hist_next[i] = {hist_reg[i][HIST_LEN-2:0], pins[i]};
            press_evt[i] = (hist_next[i] == '0) && !pressed_reg[i];
            rel_evt[i]   = (hist_next[i] == '1) && pressed_reg[i];
        end
        pressed_next = (pressed_reg | press_evt) & ~rel_evt;
    end

    assign evt.press_evt     = press_evt;
    assign evt.rel_evt       = rel_evt;
    assign evt.pressed_now   = pressed_reg;
    assign evt.pressed_after = pressed_next;

    // Histories and flags move only when a sample request is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                hist_reg[i] <= '0;
            end
            pressed_reg <= '0;
        end
        else if (step.sample)
        begin
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                hist_reg[i] <= hist_next[i];
            end
            pressed_reg <= pressed_next;
        end
    end

    `SLD_ASSERT_SAME(a_evt_disjoint, 1'b1, (press_evt & rel_evt) == '0, "press and release at once")
    `SLD_ASSERT_NEXT(a_press_sticks, step.sample, (pressed_reg & $past(press_evt)) == $past(press_evt), "pressed flag not set")
    `SLD_ASSERT_NEXT(a_hold_idle, !step.sample, $stable(pressed_reg), "pressed flags moved without a sample")

endmodule

### sv/sld_quickcast.sv
// Quickcast mode, click counter, toggle pulse and the configuration registers.
// Depends on sld_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "shift_log_button_debouncer_core_macros.svh"

module sld_quickcast (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sld_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sld_pkg::CFG_DATA_W-1:0] cfg_data,
    input  sld_pkg::step_t                 step,
    input  sld_pkg::btn_evt_t              evt,
    output sld_pkg::qc_result_t            res
);
    import sld_pkg::*;

    logic [BUTTON_COUNT-1:0] mask_reg;
    logic [BTN_IDX_W-1:0]    shop_idx_reg;
    logic [BTN_IDX_W-1:0]    qc_idx_reg;
    logic                    qc_on_reg;
    logic                    qc_on_next;
    logic [CLICK_W-1:0]      cnt_reg;
    logic [CLICK_W-1:0]      cnt_next;
    logic                    qc_press;
    logic                    shop_press;
    logic [BUTTON_COUNT-1:0] mode_at;
    logic                    click_set;

    // Configuration writes; an index past the register list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg     <= BUTTON_COUNT'(16'h0F3F);
            shop_idx_reg <= BTN_IDX_W'(12);
            qc_idx_reg   <= BTN_IDX_W'(13);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_QC_MASK:  mask_reg     <= cfg_data[BUTTON_COUNT-1:0];
                CFG_SHOP_IDX: shop_idx_reg <= cfg_data[BTN_IDX_W-1:0];
                CFG_QC_IDX:   qc_idx_reg   <= cfg_data[BTN_IDX_W-1:0];
                default:      ;
            endcase
        end
    end

    // The quickcast button flips the mode for every button above it in the same sample.
    always_comb
    begin
        qc_press   = evt.press_evt[qc_idx_reg];
        shop_press = evt.press_evt[shop_idx_reg];
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            mode_at[i] = qc_on_reg ^ (qc_press && (BTN_IDX_W'(i) > qc_idx_reg));
        end
        click_set = |(evt.rel_evt & mask_reg & mode_at);
    end

    // Next mode and counter.
    always_comb
    begin
        qc_on_next = qc_on_reg;
        cnt_next   = cnt_reg;
        if (step.sample)
        begin
            qc_on_next = qc_on_reg ^ qc_press;
            if (click_set)
            begin
                cnt_next = CLICK_W'(CLICK_REPEATS);
            end
        end
        else if (step.query && (cnt_reg != '0))
        begin
            cnt_next = cnt_reg - CLICK_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qc_on_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            qc_on_reg <= qc_on_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign res.pulse      = shop_press;
    assign res.mode_now   = qc_on_reg;
    assign res.mode_after = qc_on_reg ^ qc_press;
    assign res.click_now  = cnt_reg;

    `SLD_ASSERT_SAME(a_cnt_range, 1'b1, cnt_reg <= CLICK_W'(CLICK_REPEATS), "click counter out of range")
    `SLD_ASSERT_NEXT(a_cnt_dec, step.query && (cnt_reg != '0), cnt_reg == $past(cnt_reg) - CLICK_W'(1), "click counter did not count down")
    `SLD_ASSERT_NEXT(a_mode_hold, !step.sample, qc_on_reg == $past(qc_on_reg), "mode changed without a sample")

endmodule

### sv/shift_log_button_debouncer_core.sv
// Shift-register debouncer for 16 active-low buttons with quickcast click queueing.
// Takes one request per clock while results drain and returns one result per request.
// A request goes into an input register, then one combinational pass updates the
// histories, the debounced flags, the quickcast mode and the click counter and
// loads the result register, from which the result is offered. With the
// output side ready, the throughput is one request per cycle; a stalled result
// holds one more request in the input register before s_tready drops.
// Depends on sld_pkg, sld_history, sld_quickcast and the assertion macro header.
`timescale 1ns / 1ps
`include "shift_log_button_debouncer_core_macros.svh"

module shift_log_button_debouncer_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [sld_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sld_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sld_pkg::IN_DATA_W-1:0]   s_tdata,  // [15:0] pin_levels
    input  logic                            s_tuser,  // [0] req_type
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sld_pkg::OUT_DATA_W-1:0]  m_tdata   // [15:0] pressed_states,
                                                      // [16] mode_toggle_pulse,
                                                      // [17] quickcast_mode,
                                                      // [20:18] click_value, [23:21] zero
);
    import sld_pkg::*;

    logic                    in_valid_reg;
    logic                    in_valid_next;
    req_type_t               req_reg;
    logic [BUTTON_COUNT-1:0] pins_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [BUTTON_COUNT-1:0] pressed_out_reg;
    logic                    pulse_out_reg;
    logic                    mode_out_reg;
    logic [CLICK_W-1:0]      click_out_reg;
    logic                    advance;
    logic                    in_take;
    step_t                   step;
    btn_evt_t                evt;
    qc_result_t              qc_res;

    // The input register moves on when the result register is free or being drained.
    assign advance     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready    = !in_valid_reg || advance;
    assign in_take     = s_tvalid && s_tready;
    assign step.sample = advance && (req_reg == REQ_SAMPLE);
    assign step.query  = advance && (req_reg == REQ_QUERY);

    always_comb
    begin
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        out_valid_next = advance ? 1'b1 : (out_valid_reg && !m_tready);
    end

    // Request input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg  <= req_type_t'(s_tuser);
            pins_reg <= s_tdata[BUTTON_COUNT-1:0];
        end
    end

    sld_history u_history (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .pins  (pins_reg),
        .evt   (evt)
    );

    sld_quickcast u_quickcast (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .evt       (evt),
        .res       (qc_res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            unique case (req_reg)
                REQ_SAMPLE:
                begin
                    pressed_out_reg <= evt.pressed_after;
                    pulse_out_reg   <= qc_res.pulse;
                    mode_out_reg    <= qc_res.mode_after;
                    click_out_reg   <= '0;
                end
                REQ_QUERY:
                begin
                    pressed_out_reg <= evt.pressed_now;
                    pulse_out_reg   <= 1'b0;
                    mode_out_reg    <= qc_res.mode_now;
                    click_out_reg   <= qc_res.click_now;
                end
                default:
                begin
                    pressed_out_reg <= evt.pressed_now;
                    pulse_out_reg   <= 1'b0;
                    mode_out_reg    <= qc_res.mode_now;
                    click_out_reg   <= '0;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, click_out_reg, mode_out_reg, pulse_out_reg, pressed_out_reg};

    `SLD_ASSERT_SAME(a_ready_stall, !s_tready, in_valid_reg && out_valid_reg && !m_tready, "input stalled without a blocked result")
    `SLD_ASSERT_SAME(a_click_no_pulse, out_valid_reg && (click_out_reg != '0), !pulse_out_reg, "query result carries a pulse")
    `SLD_ASSERT_NEXT(a_out_from_in, !out_valid_reg && !in_valid_reg, !out_valid_reg, "result without a request")

endmodule

### bench/sld_debounce_checker.sv
`timescale 1ns / 1ps
// Checker for the button debouncer: watches the register port and both streams,
// predicts each result from its own copy of the debouncer state, and counts mismatches.
// Depends on sld_pkg for sizes, request kinds and register indexes.

module sld_debounce_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sld_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sld_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [sld_pkg::IN_DATA_W-1:0]   s_tdata,   // [15:0] pin_levels
    input  logic                            s_tuser,   // [0] req_type
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [sld_pkg::OUT_DATA_W-1:0]  m_tdata,   // [15:0] pressed_states,
                                                       // [16] mode_toggle_pulse,
                                                       // [17] quickcast_mode,
                                                       // [20:18] click_value
    output int                              fail_count,
    output int                              pending_count
);
    import sld_pkg::*;

    localparam logic [BUTTON_COUNT-1:0] QC_MASK_RESET  = 16'h0F3F;
    localparam logic [BTN_IDX_W-1:0]    SHOP_IDX_RESET = 4'd12;
    localparam logic [BTN_IDX_W-1:0]    QC_IDX_RESET   = 4'd13;

    typedef struct packed {
        logic [BUTTON_COUNT-1:0] pressed_states;
        logic                    toggle_pulse;
        logic                    qc_mode;
        logic [CLICK_W-1:0]      click_value;
    } btn_result_t;

    // Shadow of the debouncer state and its registers.
    logic [HIST_LEN-1:0]     pin_history [BUTTON_COUNT];
    logic [BUTTON_COUNT-1:0] debounced;
    logic                    qc_on;
    logic [CLICK_W-1:0]      clicks_left;
    logic [BUTTON_COUNT-1:0] qc_mask;
    logic [BTN_IDX_W-1:0]    shop_idx;
    logic [BTN_IDX_W-1:0]    qc_idx;

    btn_result_t expected_results [$];

    // Advance the shadow state by one request and return the result it should produce.
    task automatic debounce_step(input req_type_t kind, input logic [BUTTON_COUNT-1:0] pins,
                                 output btn_result_t res);
        res = '0;
        if (kind == REQ_SAMPLE)
        begin
            // Buttons are visited in ascending order, so a mode flip is seen above it.
            for (int b = 0; b < BUTTON_COUNT; b++)
            begin
                pin_history[b] = {pin_history[b][HIST_LEN-2:0], pins[b]};
                if (pin_history[b] == '1 && debounced[b])
                begin
                    debounced[b] = 1'b0;
                    if (qc_mask[b] && qc_on)
                        clicks_left = CLICK_W'(CLICK_REPEATS);
                end
                else if (pin_history[b] == '0 && !debounced[b])
                begin
                    debounced[b] = 1'b1;
                    if (b == int'(shop_idx))
                        res.toggle_pulse = 1'b1;
                    if (b == int'(qc_idx))
                        qc_on = ~qc_on;
                end
            end
        end
        else
        begin
            // A query reports the counter, then counts it down, stopping at zero.
            res.click_value = clicks_left;
            if (clicks_left != '0)
                clicks_left = clicks_left - CLICK_W'(1);
        end
        res.pressed_states = debounced;
        res.qc_mode        = qc_on;
    endtask

    // Unknown bits on the result count as a mismatch.
    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
        end
    endtask

    // Compare accepted results in order, then predict for an accepted request.
    always @(posedge clk or negedge rst_n)
    begin
        btn_result_t predicted;
        btn_result_t oldest;
        if (!rst_n)
        begin
            for (int b = 0; b < BUTTON_COUNT; b++)
                pin_history[b] = '0;
            debounced   = '0;
            qc_on       = 1'b0;
            clicks_left = '0;
            qc_mask     = QC_MASK_RESET;
            shop_idx    = SHOP_IDX_RESET;
            qc_idx      = QC_IDX_RESET;
            expected_results.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_QC_MASK:  qc_mask  = cfg_data[BUTTON_COUNT-1:0];
                    CFG_SHOP_IDX: shop_idx = cfg_data[BTN_IDX_W-1:0];
                    CFG_QC_IDX:   qc_idx   = cfg_data[BTN_IDX_W-1:0];
                    default:      ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with no request outstanding, actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    check_field("pressed_states", 32'(oldest.pressed_states),
                                32'(m_tdata[15:0]));
                    check_field("mode_toggle_pulse", 32'(oldest.toggle_pulse),
                                32'(m_tdata[16]));
                    check_field("quickcast_mode", 32'(oldest.qc_mode), 32'(m_tdata[17]));
                    check_field("click_value", 32'(oldest.click_value),
                                32'(m_tdata[20:18]));
                end
            end

            if (s_tvalid && s_tready)
            begin
                debounce_step(req_type_t'(s_tuser), s_tdata[BUTTON_COUNT-1:0], predicted);
                expected_results.push_back(predicted);
            end

            pending_count = expected_results.size();
        end
    end

endmodule

### bench/tb_shift_log_button_debouncer_core.sv
`timescale 1ns / 1ps
// Testbench top for the button debouncer: drives reset, register writes and requests,
// stalls the result side at random, and reports the verdict.
// Depends on sld_pkg, the debouncer core and sld_debounce_checker.

module tb_shift_log_button_debouncer_core;
    import sld_pkg::*;

    localparam int                    WATCHDOG_LIMIT  = 2000;
    localparam int                    PHASE_COUNT     = 5;
    localparam int                    ITEMS_PER_PHASE = 180;
    localparam int                    DRAIN_CYCLES    = 8;
    localparam logic [CFG_IDX_W-1:0]  CFG_SPARE_IDX   = 2'd3;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_QC_MASK;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;  // [15:0] pin_levels
    logic                   s_tuser   = REQ_SAMPLE;  // [0] req_type
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;  // [15:0] pressed_states, [16] mode_toggle_pulse,
                                      // [17] quickcast_mode, [20:18] click_value

    int                      fail_count;
    int                      pending_count;
    int                      idle_cycles = 0;
    logic [BUTTON_COUNT-1:0] held_levels = '0;
    bit                      sender_gaps_on = 1'b1;

    shift_log_button_debouncer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    sld_debounce_checker result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        forever
            #5 clk = ~clk;
    end

    // A few bits set at random, about one in eight.
    function automatic logic [BUTTON_COUNT-1:0] sparse_bits();
        logic [31:0] w;
        w = $urandom & $urandom & $urandom;
        return w[BUTTON_COUNT-1:0];
    endfunction

    // Offer one request after an optional gap and return at the edge that accepts it.
    task automatic send_request(input req_type_t kind, input logic [BUTTON_COUNT-1:0] pins);
        int roll;
        int gap;
        roll = $urandom_range(0, 99);
        gap  = 0;
        if (sender_gaps_on)
        begin
            if (roll >= 90)
                gap = $urandom_range(8, 30);
            else if (roll >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= pins;
        // s_tready only moves at a rising edge, so a high value at the falling edge
        // means the request goes in at the next rising edge.
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Stop offering and wait until every outstanding request has its result.
    task automatic drain_requests();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Write all three registers on consecutive cycles while the block is idle.
    task automatic program_registers(input logic [BUTTON_COUNT-1:0] mask,
                                     input logic [BTN_IDX_W-1:0] shop,
                                     input logic [BTN_IDX_W-1:0] qc,
                                     input bit spare_write);
        logic [31:0] junk;
        junk = $urandom;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_QC_MASK;
        cfg_data  <= mask;
        @(posedge clk);
        cfg_index <= CFG_SHOP_IDX;
        cfg_data  <= {junk[11:0], shop};
        @(posedge clk);
        cfg_index <= CFG_QC_IDX;
        cfg_data  <= {junk[27:16], qc};
        @(posedge clk);
        if (spare_write)
        begin
            // An index past the register list must leave every register alone.
            cfg_index <= CFG_SPARE_IDX;
            cfg_data  <= junk[31:16];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Mostly held levels that flip now and then with some bounce; the rest is
    // queries and raw noise.
    task automatic run_random_phase(input int count);
        int roll;
        logic [BUTTON_COUNT-1:0] bounce;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                sender_gaps_on = ($urandom_range(0, 3) != 0);
            roll = $urandom_range(0, 99);
            if (roll < 22)
                send_request(REQ_QUERY, BUTTON_COUNT'($urandom_range(0, 16'hFFFF)));
            else if (roll < 25)
                send_request(REQ_SAMPLE, BUTTON_COUNT'($urandom_range(0, 16'hFFFF)));
            else
            begin
                if ($urandom_range(0, 5) == 0)
                    held_levels = held_levels ^ sparse_bits();
                bounce = ($urandom_range(0, 4) == 0) ? sparse_bits() : '0;
                send_request(REQ_SAMPLE, held_levels ^ bounce);
            end
        end
    endtask

    // Result side: long hold-offs, always-ready stretches and random stalls.
    // The first stretch is always a long hold-off.
    initial
    begin : result_sink
        int choice;
        int span;
        bit first_hold;
        first_hold = 1'b1;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            choice     = first_hold ? 0 : $urandom_range(0, 19);
            first_hold = 1'b0;
            span       = $urandom_range(10, 40);
            if (choice < 2)
            begin
                // Hold off long enough for the block to fill and drop s_tready.
                m_tready <= 1'b0;
                repeat ($urandom_range(40, 80)) @(posedge clk);
            end
            else if (choice < 8)
            begin
                m_tready <= 1'b1;
                repeat (span) @(posedge clk);
            end
            else
            begin
                for (int k = 0; k < span; k++)
                begin
                    m_tready <= ($urandom_range(0, 2) != 0);
                    @(posedge clk);
                end
            end
        end
    end

    // End the run if nothing moves on any port for too long.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_shift_log_button_debouncer_core: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        logic [BUTTON_COUNT-1:0] mask;
        logic [BTN_IDX_W-1:0]    shop;
        logic [BTN_IDX_W-1:0]    qc;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset register values.
        send_request(REQ_QUERY, 16'hFFFF);              // counter still zero
        send_request(REQ_SAMPLE, 16'h0000);             // fresh history: all press at once
        repeat (8) send_request(REQ_SAMPLE, 16'hFFFF);  // all release, clicks queued
        repeat (4) send_request(REQ_QUERY, 16'h0000);   // count down to one
        send_request(REQ_QUERY, 16'hFFFF);              // back at zero, stays there
        send_request(REQ_SAMPLE, 16'hAAAA);
        send_request(REQ_SAMPLE, 16'h5555);
        repeat (8) send_request(REQ_SAMPLE, 16'h0000);  // press again, mode flips back
        held_levels = 16'h0000;
        drain_requests();

        // Random phases, each with its own register setting.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:       begin mask = 16'hFFFF; shop = 4'd15; qc = 4'd0;  end
                1:       begin mask = 16'h0000; shop = 4'd0;  qc = 4'd15; end
                3:       begin mask = 16'h0F3F; shop = 4'd12; qc = 4'd13; end
                default:
                begin
                    mask = BUTTON_COUNT'($urandom_range(0, 16'hFFFF));
                    shop = BTN_IDX_W'($urandom_range(0, 15));
                    qc   = (phase == 4) ? shop : BTN_IDX_W'($urandom_range(0, 15));
                end
            endcase
            program_registers(mask, shop, qc, phase == 1);
            run_random_phase(ITEMS_PER_PHASE);
            drain_requests();
        end

        // Give a stray late result time to show up.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("tb_shift_log_button_debouncer_core: PASS");
        else
            $display("tb_shift_log_button_debouncer_core: FAIL");
        $finish;
    end

endmodule
